@@ rtl/shdc_pkg.sv @@
package shdc_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned WDAY_W   = 3;
  localparam int unsigned DOY_W    = 9;
  localparam int unsigned YMOD_W   = 6;
  localparam int unsigned REQ_W    = 2;

  localparam int unsigned YEAR_CYCLE = 33;
  localparam int unsigned RESET_YEAR = 1348;
  localparam logic [YMOD_W-1:0]  RESET_YMOD  = YMOD_W'(RESET_YEAR % YEAR_CYCLE);
  localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd10;
  localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd11;
  localparam logic [WDAY_W-1:0]  RESET_WDAY  = 3'd5;

  localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
  localparam logic [WDAY_W-1:0]  WDAY_LAST   = 3'd6;
  localparam logic [YMOD_W-1:0]  YMOD_LAST   = 6'd32;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET  = 2'd0,
    REQ_FWD  = 2'd1,
    REQ_BACK = 2'd2
  } req_e;

  typedef struct packed {
    req_e               req_type;
    logic [YEAR_W-1:0]  set_year;
    logic [MONTH_W-1:0] set_month;
    logic [DAY_W-1:0]   set_day;
  } req_t;

  typedef struct packed {
    logic [YMOD_W-1:0]  ymod;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WDAY_W-1:0]  wday;
  } date_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  cur_year;
    logic [MONTH_W-1:0] cur_month;
    logic [DAY_W-1:0]   cur_day;
    logic [WDAY_W-1:0]  weekday;
    logic               leap_year;
    logic [DOY_W-1:0]   day_of_year;
    logic [DOY_W-1:0]   days_left;
    logic               set_error;
  } rsp_t;

  // 2^5 = -1 (mod 33): fold 5-bit digits with alternating sign
  function automatic logic [YMOD_W-1:0] mod33(input logic [15:0] x);
    logic [6:0] t;
    t = 7'd33 + 7'(x[4:0]) + 7'(x[14:10]) - 7'(x[9:5]) - 7'(x[15]);
    if (t >= 7'd66) begin
      t = t - 7'd66;
    end else if (t >= 7'd33) begin
      t = t - 7'd33;
    end
    return t[YMOD_W-1:0];
  endfunction

  // 2^3 = 1 (mod 7): sum octal digits twice
  function automatic logic [WDAY_W-1:0] mod7(input logic [17:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) + 6'(x[17:15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[WDAY_W-1:0];
  endfunction

  function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
    logic r;
    unique case (ymod)
      6'd1, 6'd5, 6'd9, 6'd13, 6'd17, 6'd22, 6'd26, 6'd30: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic leap, input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    if (m < 4'd7) begin
      r = 5'd31;
    end else if (m < MONTH_LAST || leap) begin
      r = 5'd30;
    end else begin
      r = 5'd29;
    end
    return r;
  endfunction

  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    unique case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd62;
      4'd4:    r = 9'd93;
      4'd5:    r = 9'd124;
      4'd6:    r = 9'd155;
      4'd7:    r = 9'd186;
      4'd8:    r = 9'd216;
      4'd9:    r = 9'd246;
      4'd10:   r = 9'd276;
      4'd11:   r = 9'd306;
      4'd12:   r = 9'd336;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/shdc_req_if.sv @@
interface shdc_req_if import shdc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [YEAR_W-1:0]  set_year;
  logic [MONTH_W-1:0] set_month;
  logic [DAY_W-1:0]   set_day;

  modport source (output valid, output req_type, output set_year, output set_month,
                  output set_day, input ready);
  modport sink   (input valid, input req_type, input set_year, input set_month,
                  input set_day, output ready);
endinterface

@@ rtl/shdc_rsp_if.sv @@
interface shdc_rsp_if import shdc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  cur_year;
  logic [MONTH_W-1:0] cur_month;
  logic [DAY_W-1:0]   cur_day;
  logic [WDAY_W-1:0]  weekday;
  logic               leap_year;
  logic [DOY_W-1:0]   day_of_year;
  logic [DOY_W-1:0]   days_left;
  logic               set_error;

  modport source (output valid, output cur_year, output cur_month, output cur_day,
                  output weekday, output leap_year, output day_of_year, output days_left,
                  output set_error, input ready);
  modport sink   (input valid, input cur_year, input cur_month, input cur_day,
                  input weekday, input leap_year, input day_of_year, input days_left,
                  input set_error, output ready);
endinterface

@@ rtl/shdc_step.sv @@
module shdc_step import shdc_pkg::*; #(
  parameter int unsigned YEAR_BITS = 14
) (
  input  req_t                 req_i,
  input  logic [YEAR_BITS-1:0] year_i,
  input  date_t                date_i,
  output logic [YEAR_BITS-1:0] year_o,
  output date_t                date_o,
  output rsp_t                 rsp_o
);

  localparam longint unsigned YearMax = (64'd1 << YEAR_BITS) - 64'd1;
  localparam logic [YMOD_W-1:0] YearMaxMod = YMOD_W'(YearMax % YEAR_CYCLE);

  logic [YEAR_BITS-1:0] set_year;
  logic [YMOD_W-1:0]    set_ymod;
  logic                 set_ok;
  logic [WDAY_W-1:0]    set_wday;
  logic [DAY_W-1:0]     cur_len;
  logic [YMOD_W-1:0]    inc_ymod;
  logic [YMOD_W-1:0]    dec_ymod;
  logic [MONTH_W-1:0]   back_month;
  logic [YMOD_W-1:0]    back_ymod;
  logic [DOY_W-1:0]     doy;
  logic                 leap_n;
  logic                 err;

  assign set_year = YEAR_BITS'(req_i.set_year);
  assign set_ymod = mod33(16'(set_year));
  assign set_ok   = (req_i.set_month >= MONTH_FIRST) && (req_i.set_month <= MONTH_LAST) &&
                    (req_i.set_day != '0) &&
                    (req_i.set_day <= month_len(is_leap(set_ymod), req_i.set_month));
  assign set_wday = mod7(18'(set_year) + 18'(set_year >> 2) + 18'(req_i.set_day) +
                         18'(days_before(req_i.set_month)));

  assign cur_len  = month_len(is_leap(date_i.ymod), date_i.month);

  // keep year mod 33 in step with the year, also across the counter wrap
  assign inc_ymod = (year_i == '1 || date_i.ymod == YMOD_LAST) ? '0 : date_i.ymod + 6'd1;
  assign dec_ymod = (year_i == '0) ? YearMaxMod :
                    (date_i.ymod == '0) ? YMOD_LAST : date_i.ymod - 6'd1;

  assign back_month = (date_i.month <= MONTH_FIRST) ? MONTH_LAST : date_i.month - 4'd1;
  assign back_ymod  = (date_i.month <= MONTH_FIRST) ? dec_ymod : date_i.ymod;

  always_comb begin
    year_o = year_i;
    date_o = date_i;
    err    = 1'b0;
    unique case (req_i.req_type)
      REQ_SET: begin
        if (set_ok) begin
          year_o = set_year;
          date_o = '{ymod: set_ymod, month: req_i.set_month, day: req_i.set_day,
                     wday: set_wday};
        end else begin
          err = 1'b1;
        end
      end
      REQ_FWD: begin
        if (date_i.day >= cur_len) begin
          date_o.day = 5'd1;
          if (date_i.month >= MONTH_LAST) begin
            date_o.month = MONTH_FIRST;
            date_o.ymod  = inc_ymod;
            year_o       = year_i + 1'b1;
          end else begin
            date_o.month = date_i.month + 4'd1;
          end
        end else begin
          date_o.day = date_i.day + 5'd1;
        end
        date_o.wday = (date_i.wday >= WDAY_LAST) ? '0 : date_i.wday + 3'd1;
      end
      REQ_BACK: begin
        if (date_i.day <= 5'd1) begin
          date_o.month = back_month;
          date_o.ymod  = back_ymod;
          date_o.day   = month_len(is_leap(back_ymod), back_month);
          if (date_i.month <= MONTH_FIRST) begin
            year_o = year_i - 1'b1;
          end
        end else begin
          date_o.day = date_i.day - 5'd1;
        end
        date_o.wday = (date_i.wday == '0) ? WDAY_LAST : date_i.wday - 3'd1;
      end
      default: begin
        // unused request code: hold everything
        err = 1'b0;
      end
    endcase
  end

  assign doy    = days_before(date_o.month) + DOY_W'(date_o.day);
  assign leap_n = is_leap(date_o.ymod);

  assign rsp_o = '{
    cur_year:    YEAR_W'(year_o),
    cur_month:   date_o.month,
    cur_day:     date_o.day,
    weekday:     date_o.wday,
    leap_year:   leap_n,
    day_of_year: doy,
    days_left:   (leap_n ? 9'd366 : 9'd365) - doy,
    set_error:   err
  };

endmodule

@@ rtl/solar_hijri_date_counter_top.sv @@
// Persian solar calendar date counter with weekday.
// Request channel req_i: req_type 0 loads set_year/set_month/set_day and
// recomputes the weekday, 1 steps one day forward, 2 steps one day back,
// 3 leaves the date alone. A load with a bad month or day is dropped and
// flagged by set_error in its response.
// Response channel rsp_o: exactly one response per request, in order, with
// the date held after that request, weekday (0 Saturday), leap flag, day of
// year and days left in the year.
// Path: an accepted request sits in the input register; the step logic then
// updates the date registers and loads the result register, which drives rsp_o.
// Throughput: one request per cycle while rsp_o.ready is high; date and
// response registers update together, so back-to-back steps have no bubbles.
// Stall: while rsp_o.ready is low the response holds; one more request is
// taken into the input register, after which req_i.ready drops.
// Reset (rst_ni low, asynchronous): both stages empty, date 1348-10-11,
// weekday Thursday. YEAR_BITS sets the year counter width; the year wraps
// modulo 2^YEAR_BITS and shows on the 14-bit year fields.
module solar_hijri_date_counter_top import shdc_pkg::*; #(
  parameter int unsigned YEAR_BITS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  shdc_req_if.sink    req_i,
  shdc_rsp_if.source  rsp_o
);

  logic                 in_valid_q;
  req_t                 in_q;
  logic                 out_valid_q;
  rsp_t                 out_q;
  logic                 out_load;
  logic [YEAR_BITS-1:0] year_q;
  logic [YEAR_BITS-1:0] year_d;
  date_t                date_q;
  date_t                date_d;
  rsp_t                 rsp_d;

  assign out_load    = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= '{req_type: req_e'(req_i.req_type), set_year: req_i.set_year,
                set_month: req_i.set_month, set_day: req_i.set_day};
    end
  end

  shdc_step #(
    .YEAR_BITS(YEAR_BITS)
  ) u_step (
    .req_i  (in_q),
    .year_i (year_q),
    .date_i (date_q),
    .year_o (year_d),
    .date_o (date_d),
    .rsp_o  (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q      <= YEAR_BITS'(RESET_YEAR);
      date_q      <= '{ymod: RESET_YMOD, month: RESET_MONTH, day: RESET_DAY, wday: RESET_WDAY};
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      year_q      <= year_d;
      date_q      <= date_d;
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= rsp_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.cur_year    = out_q.cur_year;
  assign rsp_o.cur_month   = out_q.cur_month;
  assign rsp_o.cur_day     = out_q.cur_day;
  assign rsp_o.weekday     = out_q.weekday;
  assign rsp_o.leap_year   = out_q.leap_year;
  assign rsp_o.day_of_year = out_q.day_of_year;
  assign rsp_o.days_left   = out_q.days_left;
  assign rsp_o.set_error   = out_q.set_error;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    date_q.ymod == mod33(16'(year_q)))
    else $error("year mod 33 out of step with year");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    date_q.day != '0 && date_q.month >= MONTH_FIRST && date_q.month <= MONTH_LAST &&
    date_q.day <= month_len(is_leap(date_q.ymod), date_q.month))
    else $error("held date is not a calendar date");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (10'(rsp_o.day_of_year) + 10'(rsp_o.days_left)) ==
                    (rsp_o.leap_year ? 10'd366 : 10'd365))
    else $error("day of year and days left disagree with year length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && in_q.req_type == REQ_FWD |=>
      date_q.wday == (($past(date_q.wday) >= WDAY_LAST) ? 3'd0 : $past(date_q.wday) + 3'd1))
    else $error("weekday did not advance on forward step");
`endif

endmodule
